// ----- design/vehist_pkg.sv -----
// Shared types and codes for the variable-edge histogram.
// Holds the input and result item structs and the operation codes.
// No dependencies.
package vehist_pkg;

	localparam logic [1:0] OP_ADD        = 2'd0;
	localparam logic [1:0] OP_WRITE_EDGE = 2'd1;
	localparam logic [1:0] OP_READ_COUNT = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] sample_value;
		logic [5:0]         slot_index;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic [4:0]  chosen_bin;
		logic [31:0] count_value;
	} out_item_t;

endpackage

// ----- design/variable_edge_histogram.sv -----
// Variable-edge histogram engine; depends on vehist_pkg for item types and operation codes.
// An add runs LO, HI, P0, the halving steps of the shared comparator in SRCH, CRD and DONE;
// a rejected add goes from P0 to DONE, a read runs CRD and DONE, and any other code goes to
// DONE; the next item is taken the cycle after DONE hands off its result. The edge and count
// memories each have one registered read port, which sets one step a cycle. Reset clears
// control and zeroes the count memory one bin a cycle, taking no item; edges stay undefined.
module variable_edge_histogram #(
	parameter int MAX_BINS    = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  vehist_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output vehist_pkg::out_item_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [5:0]            bins_in_use
);
	import vehist_pkg::*;

	// Edge index width covers edges 0..MAX_BINS. Search positions must also hold MAX_BINS + 1.
	localparam int EW   = $clog2(MAX_BINS + 1);
	localparam int PosW = $clog2(MAX_BINS + 2);
	localparam int CW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	// The sequencer is one-hot. CLEAR zeroes the counts after reset. LO and HI fetch the range
	// limits, P0 checks the top limit and issues the first probe, SRCH runs one halving step a
	// cycle, CRD reads the count of the chosen bin, and DONE updates it and hands off the result.
	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_LO    = 8'b0000_0100,
		ST_HI    = 8'b0000_1000,
		ST_P0    = 8'b0001_0000,
		ST_SRCH  = 8'b0010_0000,
		ST_CRD   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	state_t                  state_d;
	logic [5:0]              bins_q;
	logic [1:0]              op_q;
	logic signed [VALUE_WIDTH-1:0] sample_q;
	logic [EW-1:0]           n_q;
	logic                    rej_q;
	logic                    hit_q;
	logic [PosW-1:0]         first_q;
	logic [PosW-1:0]         len_q;
	logic [EW-1:0]           probe_q;
	logic [CW-1:0]           cidx_q;
	logic [CW-1:0]           clr_q;
	logic                    out_valid_q;
	out_item_t               out_data_q;

	// Memories and their registered read data.
	logic signed [VALUE_WIDTH-1:0] edge_mem [MAX_BINS+1];
	logic [31:0]                   count_mem [MAX_BINS];
	logic signed [VALUE_WIDTH-1:0] edge_rd_q;
	logic [31:0]                   count_rd_q;

	logic                    in_fire;
	logic                    out_free;
	logic [31:0]             raw;
	logic [EW-1:0]           n_eff;
	logic                    cmp_lt;
	logic                    cmp_eq;
	logic                    cmp_gt;
	logic [PosW-1:0]         half;
	logic [PosW-1:0]         len0;
	logic [PosW-1:0]         first_nx;
	logic [PosW-1:0]         len_nx;
	logic [EW-1:0]           probe_nx;
	logic [CW-1:0]           bin_of_first;
	logic [EW-1:0]           edge_raddr;
	logic [CW-1:0]           count_raddr;
	logic                    count_we;
	logic [CW-1:0]           count_waddr;
	logic [31:0]             count_wdata;
	logic [31:0]             count_next;
	out_item_t               result;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;

	// The sample enters as a raw bit pattern sized to the edge width, like a written edge.
	assign raw = in_data.sample_value;

	// A register value of zero acts as one bin, and a value beyond the memory acts as full.
	always_comb begin
		if (bins_q == 6'd0) begin
			n_eff = EW'(1);
		end else if (32'(bins_q) > 32'(MAX_BINS)) begin
			n_eff = EW'(MAX_BINS);
		end else begin
			n_eff = EW'(bins_q);
		end
	end

	// The one shared comparator: the sample against whatever edge was just read.
	assign cmp_lt = sample_q < edge_rd_q;
	assign cmp_eq = sample_q == edge_rd_q;
	assign cmp_gt = !cmp_lt && !cmp_eq;

	// One upper-bound halving step. An edge not above the sample moves the lower end past the
	// probe; otherwise the span shrinks to its lower half.
	assign half = len_q >> 1;
	assign len0 = PosW'(n_q) + PosW'(1);
	always_comb begin
		if (!cmp_lt) begin
			first_nx = PosW'(probe_q) + PosW'(1);
			len_nx   = len_q - half - PosW'(1);
		end else begin
			first_nx = first_q;
			len_nx   = half;
		end
		probe_nx = EW'(first_nx + (len_nx >> 1));
	end

	// The sample lies in the bin below the first greater edge. When no edge is greater, it
	// belongs to the top bin, which is closed at its upper edge.
	always_comb begin
		if (first_q > PosW'(n_q)) begin
			bin_of_first = CW'(n_q - EW'(1));
		end else if (first_q == '0) begin
			bin_of_first = '0;
		end else begin
			bin_of_first = CW'(first_q - PosW'(1));
		end
	end

	always_comb begin
		unique case (state_q)
			ST_HI:   edge_raddr = n_q;
			ST_P0:   edge_raddr = EW'(len0 >> 1);
			ST_SRCH: edge_raddr = probe_nx;
			default: edge_raddr = '0;
		endcase
	end

	// During CRD an add fetches the bin found by the search; otherwise the held index stays on
	// the port so that the read data holds while the result waits.
	assign count_raddr = (state_q == ST_CRD && op_q == OP_ADD) ? bin_of_first : cidx_q;

	assign count_next  = count_rd_q + 32'd1;
	assign count_we    = (state_q == ST_CLEAR) ||
		(state_q == ST_DONE && out_free && op_q == OP_ADD && hit_q);
	assign count_waddr = (state_q == ST_CLEAR) ? clr_q : cidx_q;
	assign count_wdata = (state_q == ST_CLEAR) ? 32'd0 : count_next;

	// Result fields are zero unless the item hit a bin: a counted add or an in-range read.
	always_comb begin
		result.accepted   = hit_q && (op_q == OP_ADD);
		result.chosen_bin = hit_q ? 5'(cidx_q) : 5'd0;
		if (!hit_q) begin
			result.count_value = 32'd0;
		end else if (op_q == OP_ADD) begin
			result.count_value = count_next;
		end else begin
			result.count_value = count_rd_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CW'(MAX_BINS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					unique case (in_data.operation)
						OP_ADD:        state_d = ST_LO;
						OP_READ_COUNT: state_d = ST_CRD;
						default:       state_d = ST_DONE;
					endcase
				end
			end
			ST_LO:   state_d = ST_HI;
			ST_HI:   state_d = ST_P0;
			ST_P0:   state_d = (rej_q || cmp_gt) ? ST_DONE : ST_SRCH;
			ST_SRCH: begin
				if (len_nx == '0) begin
					state_d = ST_CRD;
				end
			end
			ST_CRD:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			bins_q      <= 6'd20;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				bins_q <= bins_in_use;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item context and search registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= in_data.operation;
			sample_q <= VALUE_WIDTH'(raw);
			n_q      <= n_eff;
			cidx_q   <= CW'(in_data.slot_index);
			hit_q    <= (in_data.operation == OP_READ_COUNT) &&
				(32'(in_data.slot_index) < 32'(MAX_BINS));
		end
		if (state_q == ST_HI) begin
			rej_q <= cmp_lt;
		end
		if (state_q == ST_P0) begin
			hit_q   <= !(rej_q || cmp_gt);
			first_q <= '0;
			len_q   <= len0;
			probe_q <= EW'(len0 >> 1);
		end
		if (state_q == ST_SRCH) begin
			first_q <= first_nx;
			len_q   <= len_nx;
			probe_q <= probe_nx;
		end
		if (state_q == ST_CRD) begin
			cidx_q <= count_raddr;
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= result;
		end
	end

	// Edge memory: written straight from the accepted item, read one edge a cycle.
	always_ff @(posedge clk) begin
		if (in_fire && in_data.operation == OP_WRITE_EDGE &&
			32'(in_data.slot_index) <= 32'(MAX_BINS)) begin
			edge_mem[EW'(in_data.slot_index)] <= VALUE_WIDTH'(raw);
		end
		edge_rd_q <= edge_mem[edge_raddr];
	end

	// Count memory: one write port shared by the clearing pass and the increment.
	always_ff @(posedge clk) begin
		if (count_we) begin
			count_mem[count_waddr] <= count_wdata;
		end
		count_rd_q <= count_mem[count_raddr];
	end

`ifndef NO_ASSERTIONS
	a_search_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> len_q != '0)
		else $error("search step entered with an empty span");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> probe_q <= n_q)
		else $error("search probe beyond the top edge in use");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the hand-off state");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q == ST_CLEAR) && state_q == ST_IDLE) |->
			$past(clr_q) == CW'(MAX_BINS - 1))
		else $error("clearing pass ended before the last bin");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && hit_q) |-> 32'(cidx_q) < 32'(MAX_BINS))
		else $error("counted bin outside the count memory");
`endif

endmodule

// ----- tb/variable_edge_histogram_test.sv -----
// Self-checking testbench for the variable-edge histogram engine.
// Depends on vehist_pkg for item types and operation codes and on the
// variable_edge_histogram RTL; no other files are needed.
module variable_edge_histogram_test;

	import vehist_pkg::*;

	// The package names three operations; the fourth code does nothing.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         BIN_SLOTS = 32;
	localparam int         LONG_HOLD = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_bins;

	// Shadow of the block's state, kept in step with every accepted item.
	logic signed [31:0] edge_mem [0:BIN_SLOTS];
	logic [BIN_SLOTS:0] edge_seen;
	logic [31:0]        tally [0:BIN_SLOTS-1];
	logic [5:0]         bin_setting;

	// Results still owed by the block, oldest first.
	out_item_t due_reports [$];
	int        mismatch_total;

	// Shared knobs between the test tasks, the sender task and the receiver process.
	bit idle_enable;
	int hold_off_cycles;

	variable_edge_histogram u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.bins_in_use (cfg_bins)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A zero setting behaves as one bin, and anything above the table size
	// behaves as the full table.
	function automatic int active_bins();
		if (bin_setting == 6'd0)
			return 1;
		if (bin_setting > 6'(BIN_SLOTS))
			return BIN_SLOTS;
		return int'(bin_setting);
	endfunction

	// Works out the result of one item and applies its side effects to the
	// shadow state. The search is an upper-bound halving over edges 0..n and
	// is run the same way whether or not the edges happen to be sorted.
	function automatic out_item_t apply_item(in_item_t it);
		out_item_t          r;
		logic signed [31:0] s;
		int                 n, first, len, half, probe, b;
		r = '0;
		s = it.sample_value;
		case (it.operation)
			OP_ADD: begin
				n = active_bins();
				if (!(s < edge_mem[0]) && !(s > edge_mem[n])) begin
					first = 0;
					len   = n + 1;
					while (len > 0) begin
						half  = len / 2;
						probe = first + half;
						if (!(s < edge_mem[probe])) begin
							first = probe + 1;
							len   = len - (half + 1);
						end else begin
							len = half;
						end
					end
					// Nothing above the sample means it sits on the closed top edge.
					if (first > n)
						b = n - 1;
					else if (first == 0)
						b = 0;
					else
						b = first - 1;
					tally[b]      = tally[b] + 32'd1;
					r.accepted    = 1'b1;
					r.chosen_bin  = 5'(b);
					r.count_value = tally[b];
				end
			end
			OP_WRITE_EDGE: begin
				if (int'(it.slot_index) <= BIN_SLOTS) begin
					edge_mem[it.slot_index]  = it.sample_value;
					edge_seen[it.slot_index] = 1'b1;
				end
			end
			OP_READ_COUNT: begin
				if (int'(it.slot_index) < BIN_SLOTS) begin
					r.chosen_bin  = it.slot_index[4:0];
					r.count_value = tally[it.slot_index];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic in_item_t make_item(logic [1:0] op, logic signed [31:0] value,
			logic [5:0] slot);
		in_item_t it;
		it.operation    = op;
		it.sample_value = value;
		it.slot_index   = slot;
		return it;
	endfunction

	// Sender side: an optional idle burst, then valid stays up until the
	// block takes the item. Valid is left high so back-to-back items flow.
	task automatic offer_item(in_item_t it);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		due_reports.insert(due_reports.size(), apply_item(it));
	endtask

	// Stops offering and waits until every owed result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (due_reports.size() != 0);
	endtask

	// The bin count register is only written while the block is idle.
	task automatic write_bins(logic [5:0] setting);
		cfg_valid <= 1'b1;
		cfg_bins  <= setting;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		bin_setting = setting;
		cfg_valid <= 1'b0;
	endtask

	// Writes edge slots 0 to 32 in ascending order. The spacing style varies:
	// tight steps, huge steps that pile up on the top value, or medium steps.
	// An occasional zero step leaves two equal edges.
	task automatic write_sorted_edges();
		longint level;
		int     step_cap;
		case ($urandom_range(0, 2))
			0: begin
				level    = longint'($signed($urandom)) / 4096;
				step_cap = 16;
			end
			1: begin
				level    = -64'sd2147483648 + longint'($urandom_range(0, 1 << 20));
				step_cap = 1 << 27;
			end
			default: begin
				level    = longint'($signed($urandom)) / 1024;
				step_cap = 1 << 16;
			end
		endcase
		for (int k = 0; k <= BIN_SLOTS; k++) begin
			if (level > 64'sd2147483647)
				level = 64'sd2147483647;
			offer_item(make_item(OP_WRITE_EDGE, 32'(level), 6'(k)));
			if ($urandom_range(0, 7) != 0)
				level = level + longint'($urandom_range(1, step_cap));
		end
	endtask

	// Draws one item from the current shadow state. Most items are samples
	// aimed at the edges, just past them or between them; the rest are reads,
	// stray edge writes and the unused code. An add is only drawn once edges
	// 0..n have all been written, so the block never searches an empty entry.
	function automatic in_item_t draw_item(int noise_pct);
		in_item_t           it;
		int                 n, k, pick;
		bit                 edges_ready;
		longint             lo, hi;
		logic signed [31:0] s;
		n           = active_bins();
		edges_ready = 1'b1;
		for (int i = 0; i <= n; i++)
			if (!edge_seen[i])
				edges_ready = 1'b0;
		it.operation    = OP_ADD;
		it.sample_value = $urandom;
		it.slot_index   = 6'($urandom_range(0, 63));
		pick = $urandom_range(0, 99);
		if (pick < noise_pct) begin
			it.operation = ($urandom_range(0, 2) == 0) ? OP_UNUSED : OP_WRITE_EDGE;
			if (it.operation == OP_WRITE_EDGE && $urandom_range(0, 3) != 0)
				it.slot_index = 6'($urandom_range(0, BIN_SLOTS));
		end else if (pick < noise_pct + 18 || !edges_ready) begin
			it.operation = OP_READ_COUNT;
			if ($urandom_range(0, 3) != 0)
				it.slot_index = 6'($urandom_range(0, n - 1));
		end else begin
			k = $urandom_range(0, n);
			case ($urandom_range(0, 9))
				0, 1: s = $urandom;
				2, 3: s = edge_mem[k];
				4:    s = edge_mem[k] + 32'sd1;
				5:    s = edge_mem[k] - 32'sd1;
				6:    s = edge_mem[0] - 32'sd1;
				7:    s = edge_mem[n] + 32'sd1;
				default: begin
					k  = $urandom_range(0, n - 1);
					lo = edge_mem[k];
					hi = edge_mem[k + 1];
					if (hi >= lo)
						s = 32'(lo + longint'($urandom) % (hi - lo + 1));
					else
						s = edge_mem[k];
				end
			endcase
			it.sample_value = s;
		end
		return it;
	endfunction

	task automatic run_random(int count, int noise_pct);
		for (int i = 0; i < count; i++)
			offer_item(draw_item(noise_pct));
	endtask

	// Right after reset only reads and ignored items are legal, since no
	// edge exists yet. Counts must all read back as zero.
	task automatic test_after_reset();
		offer_item(make_item(OP_READ_COUNT, 32'sd0, 6'd0));
		offer_item(make_item(OP_READ_COUNT, -32'sd1, 6'd31));
		offer_item(make_item(OP_READ_COUNT, 32'sd0, 6'd32));
		offer_item(make_item(OP_READ_COUNT, 32'sd5, 6'd63));
		offer_item(make_item(OP_UNUSED, -32'sd1, 6'd63));
		offer_item(make_item(OP_WRITE_EDGE, 32'sd7, 6'd33));
		offer_item(make_item(OP_WRITE_EDGE, -32'sd1, 6'd63));
	endtask

	// One bin: first spanning the whole value range, then a narrow one with
	// samples just outside, on the bottom edge and on the closed top edge.
	task automatic test_single_bin();
		settle();
		write_bins(6'd1);
		offer_item(make_item(OP_WRITE_EDGE, 32'sh8000_0000, 6'd0));
		offer_item(make_item(OP_WRITE_EDGE, 32'sh7FFF_FFFF, 6'd1));
		offer_item(make_item(OP_ADD, 32'sh8000_0000, 6'd0));
		offer_item(make_item(OP_ADD, 32'sh7FFF_FFFF, 6'd63));
		offer_item(make_item(OP_ADD, 32'sd0, 6'd0));
		offer_item(make_item(OP_READ_COUNT, 32'sd0, 6'd0));
		offer_item(make_item(OP_WRITE_EDGE, -32'sd100, 6'd0));
		offer_item(make_item(OP_WRITE_EDGE, 32'sd100, 6'd1));
		offer_item(make_item(OP_ADD, -32'sd101, 6'd0));
		offer_item(make_item(OP_ADD, 32'sd101, 6'd0));
		offer_item(make_item(OP_ADD, -32'sd100, 6'd0));
		offer_item(make_item(OP_ADD, 32'sd100, 6'd0));
		offer_item(make_item(OP_READ_COUNT, 32'sd0, 6'd0));
	endtask

	// A zero bin setting must act exactly like a setting of one.
	task automatic test_zero_bin_setting();
		settle();
		write_bins(6'd0);
		offer_item(make_item(OP_ADD, 32'sd100, 6'd0));
		offer_item(make_item(OP_ADD, 32'sd101, 6'd0));
		offer_item(make_item(OP_ADD, -32'sd3, 6'd0));
		offer_item(make_item(OP_READ_COUNT, 32'sd0, 6'd1));
	endtask

	// Random traffic under a range of bin settings, including the full table,
	// settings above it and a two-bin one. Idling is switched off in
	// some phases to get stretches of back-to-back traffic.
	task automatic test_bin_settings();
		logic [5:0] plan [0:5];
		plan[0] = 6'd32;
		plan[1] = 6'd63;
		plan[2] = 6'd33;
		plan[3] = 6'd2;
		plan[4] = 6'($urandom_range(3, 31));
		plan[5] = 6'd20;
		for (int p = 0; p < 6; p++) begin
			settle();
			write_bins(plan[p]);
			idle_enable = (p % 3 != 2);
			if (p == 0 || $urandom_range(0, 1) == 1)
				write_sorted_edges();
			run_random(140, 5);
		end
		idle_enable = 1'b1;
	endtask

	// The receiver holds off for a long stretch while items keep coming, so
	// the block has to back up and stall its input.
	task automatic test_output_backpressure();
		settle();
		write_bins(6'($urandom_range(1, 32)));
		idle_enable     = 1'b0;
		hold_off_cycles = LONG_HOLD;
		run_random(40, 5);
		idle_enable = 1'b1;
	endtask

	// Edges in no particular order: the search still has a defined answer.
	task automatic test_unsorted_edges();
		settle();
		write_bins(6'($urandom_range(1, 63)));
		for (int k = 0; k <= BIN_SLOTS; k++)
			offer_item(make_item(OP_WRITE_EDGE, $urandom, 6'(k)));
		run_random(100, 25);
	endtask

	// The closing stretch runs with no idling on either side.
	task automatic test_full_rate();
		settle();
		idle_enable = 1'b0;
		write_bins(6'd32);
		write_sorted_edges();
		run_random(150, 5);
	endtask

	// Receiver side. A requested hold-off wins; otherwise ready drops in
	// random bursts while idling is enabled.
	initial begin : sink_ready
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else if (idle_enable && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Each result taken from the block is matched against the oldest
	// outstanding prediction.
	always @(posedge clk) begin : report_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_reports.size() == 0) begin
				$error("result item arrived with no prediction outstanding");
				mismatch_total++;
			end else begin
				want = due_reports.pop_front();
				if (out_data.accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
					mismatch_total++;
				end
				if (out_data.chosen_bin !== want.chosen_bin) begin
					$error("chosen_bin: expected %0d, got %0d", want.chosen_bin,
						out_data.chosen_bin);
					mismatch_total++;
				end
				if (out_data.count_value !== want.count_value) begin
					$error("count_value: expected %0d, got %0d", want.count_value,
						out_data.count_value);
					mismatch_total++;
				end
			end
		end
	end

	initial begin : run_tests
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		in_data         <= '0;
		cfg_valid       <= 1'b0;
		cfg_bins        <= 6'd20;
		idle_enable     = 1'b1;
		hold_off_cycles = 0;
		mismatch_total  = 0;
		bin_setting     = 6'd20;
		edge_seen       = '0;
		for (int i = 0; i < BIN_SLOTS; i++)
			tally[i] = 32'd0;
		for (int i = 0; i <= BIN_SLOTS; i++)
			edge_mem[i] = 32'sd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_single_bin();
		test_zero_bin_setting();
		test_bin_settings();
		test_output_backpressure();
		test_unsorted_edges();
		test_full_rate();

		// Let the last results drain, then watch a little longer for strays.
		settle();
		repeat (20) @(posedge clk);
		if (mismatch_total == 0 && due_reports.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Catches a hung handshake; well beyond the slowest legal run.
	initial begin : watchdog
		#8000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
